// File: rtl/core/palette_reduce_8bpp_to_4bpp_assert.svh
// Assertion macros shared by the palette reduction RTL.
`ifndef PALETTE_REDUCE_8BPP_TO_4BPP_ASSERT_SVH
`define PALETTE_REDUCE_8BPP_TO_4BPP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PRD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/prd_pkg.sv
// Shared constants, result codes and the command type of the palette reducer.
package prd_pkg;

   localparam int SLOTS      = 16;
   localparam int MAX_COLORS = 16;
   localparam int NIB_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int SRC_DEPTH  = 256;
   localparam int SRC_AW     = $clog2(SRC_DEPTH);
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int COUNT_W    = $clog2(SLOTS + 1);
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int KIND_W     = 2;

   localparam logic [KIND_W-1:0] RK_BYTE   = 2'd0;
   localparam logic [KIND_W-1:0] RK_ENTRY  = 2'd1;
   localparam logic [KIND_W-1:0] RK_STATUS = 2'd2;

   localparam logic ITEM_LOAD  = 1'b0;
   localparam logic ITEM_PIXEL = 1'b1;

   // One classified pixel, as handed from the front part to the back part.
   typedef struct packed {
      logic               has_color;
      logic [SLOT_W-1:0]  color_slot;
      logic [COLOR_W-1:0] color;
      logic               has_byte;
      logic [BYTE_W-1:0]  packed_byte;
      logic               has_end;
      logic               success;
   } cmd_type;

endpackage

// File: rtl/core/palette_reduce_8bpp_to_4bpp.sv
// Top level of the 8bpp to 4bpp palette reducer.
//
// Input channel (req_push / req_full): a load item (req_kind = 0) writes one
// 32-bit color into the 256-entry source palette; a pixel item (req_kind = 1)
// reads its color there, matches it against up to 16 colors seen in the image
// and gets a 4-bit slot. Slot pairs leave as packed bytes, earlier pixel high.
// On req_last_pixel the 16 reduced palette entries and a status follow, or only
// a failing status if a 17th color was seen; then the per-image state clears.
// Result channel (rsp_empty / rsp_pop): queue-style, oldest result on the ports.
// Throughput: one item per cycle while req_full is low; the source palette RAM
// read happens at the transfer edge and the parallel 16-way color compare fills
// the one lookup stage. A pixel's result then passes the command queue and the
// result register. An image within 16 colors ends in the back part with the last
// byte, the 16 entries and the status; an overflowed image ends with only the
// status. Meanwhile the front keeps taking items until its four-entry
// command queue, counting the item in lookup, is full.
// When the receiver stalls, the result register holds and the queue fills,
// then req_full rises. Reset clears all control state and empties the per-image color
// store; the source palette is not cleared and must be loaded before use.
module palette_reduce_8bpp_to_4bpp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [prd_pkg::SRC_AW-1:0]    req_entry_index,
   input  logic [prd_pkg::COLOR_W-1:0]   req_entry_color,
   input  logic [prd_pkg::SRC_AW-1:0]    req_pixel,
   input  logic                          req_last_pixel,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [prd_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [prd_pkg::BYTE_W-1:0]    rsp_packed_byte,
   output logic [prd_pkg::NIB_W-1:0]     rsp_new_index,
   output logic [prd_pkg::COLOR_W-1:0]   rsp_new_color,
   output logic                          rsp_success,
   output logic                          rsp_run_end
);
   import prd_pkg::*;

   logic                cmd_push;
   cmd_type             cmd;
   cmd_type             head;
   logic                q_empty;
   logic                q_pop;
   logic [QCNT_W-1:0]   q_count;

   prd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_color (req_entry_color),
      .req_pixel       (req_pixel),
      .req_last_pixel  (req_last_pixel),
      .q_count         (q_count),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   prd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .count    (q_count)
   );

   prd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_new_index   (rsp_new_index),
      .rsp_new_color   (rsp_new_color),
      .rsp_success     (rsp_success),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

// File: rtl/core/prd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/prd_front.sv
// Front part: takes items, looks up pixel colors, matches them and packs slots.
`include "palette_reduce_8bpp_to_4bpp_assert.svh"

module prd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [prd_pkg::SRC_AW-1:0]    req_entry_index,
   input  logic [prd_pkg::COLOR_W-1:0]   req_entry_color,
   input  logic [prd_pkg::SRC_AW-1:0]    req_pixel,
   input  logic                          req_last_pixel,
   input  logic [prd_pkg::QCNT_W-1:0]    q_count,
   output logic                          cmd_push,
   output prd_pkg::cmd_type              cmd
);
   import prd_pkg::*;

   logic                 accept;
   logic [QCNT_W:0]      credit_used;
   logic [COLOR_W-1:0]   color;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff;

   logic [COLOR_W-1:0]   uc_ff [SLOTS];
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [NIB_W-1:0]     held_ff, held_in;
   logic                 wait_ff, wait_in;
   logic                 ovf_ff, ovf_in;

   logic [SLOTS-1:0]     match;
   logic                 found;
   logic [SLOT_W-1:0]    slot_hit;
   logic [SLOT_W-1:0]    new_slot;
   logic                 add_new;

   // Reserve a queue entry for the item in the lookup stage as well.
   assign credit_used = {1'b0, q_count} + (QCNT_W + 1)'(s1_valid_ff);
   assign req_full    = credit_used >= (QCNT_W + 1)'(QDEPTH);
   assign accept      = req_push && !req_full;
   assign s1_valid_in = accept && (req_kind == ITEM_PIXEL);

   prd_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (SRC_DEPTH)
   ) u_src_palette (
      .clock   (clock),
      .wr_en   (accept && (req_kind == ITEM_LOAD)),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_color),
      .rd_en   (s1_valid_in),
      .rd_addr (req_pixel),
      .rd_data (color)
   );

   always_comb begin
      found    = 1'b0;
      slot_hit = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = (COUNT_W'(i) < count_ff) && (uc_ff[i] == color);
         if (match[i]) begin
            slot_hit = slot_hit | SLOT_W'(i);
         end
      end
      found    = |match;
      new_slot = found ? slot_hit : count_ff[SLOT_W-1:0];
   end

   always_comb begin
      ovf_in   = ovf_ff;
      count_in = count_ff;
      held_in  = held_ff;
      wait_in  = wait_ff;
      add_new  = 1'b0;
      cmd      = '0;
      cmd_push = 1'b0;
      if (s1_valid_ff) begin
         if (!ovf_ff) begin
            if (!found) begin
               if (count_ff >= COUNT_W'(MAX_COLORS)) begin
                  ovf_in = 1'b1;
               end else begin
                  add_new        = 1'b1;
                  count_in       = count_ff + COUNT_W'(1);
                  cmd.has_color  = 1'b1;
                  cmd.color_slot = new_slot;
                  cmd.color      = color;
               end
            end
            if (!ovf_in) begin
               if (wait_ff) begin
                  cmd.has_byte    = 1'b1;
                  cmd.packed_byte = {held_ff, new_slot};
                  wait_in         = 1'b0;
                  held_in         = '0;
               end else if (s1_last_ff) begin
                  cmd.has_byte    = 1'b1;
                  cmd.packed_byte = {new_slot, NIB_W'(0)};
               end else begin
                  held_in = new_slot;
                  wait_in = 1'b1;
               end
            end
         end
         if (s1_last_ff) begin
            cmd.has_end = 1'b1;
            cmd.success = !ovf_in;
            // start the next image from scratch
            ovf_in   = 1'b0;
            count_in = '0;
            held_in  = '0;
            wait_in  = 1'b0;
         end
         cmd_push = cmd.has_color || cmd.has_byte || cmd.has_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         held_ff     <= '0;
         wait_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         held_ff     <= held_in;
         wait_ff     <= wait_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req_last_pixel;
      end
      if (add_new) begin
         uc_ff[count_ff[SLOT_W-1:0]] <= color;
      end
   end

   `PRD_ASSERT_IMPLIES(a_count_in_range, s1_valid_ff, count_ff <= COUNT_W'(MAX_COLORS),
      "unique color count beyond limit")

endmodule

// File: rtl/core/prd_queue.sv
// Short command queue between the front and back parts.
`include "palette_reduce_8bpp_to_4bpp_assert.svh"

module prd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  prd_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output prd_pkg::cmd_type           head,
   output logic                       empty,
   output logic [prd_pkg::QCNT_W-1:0] count
);
   import prd_pkg::*;

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = entry_ff[rd_ptr_ff];
   assign count  = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PRD_ASSERT_IMPLIES(a_no_push_when_full, push, count_ff != QCNT_W'(QDEPTH),
      "command pushed into a full queue")

endmodule

// File: rtl/core/prd_back.sv
// Back part: expands commands into packed bytes, palette entries and status.
`include "palette_reduce_8bpp_to_4bpp_assert.svh"

module prd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  prd_pkg::cmd_type              head,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [prd_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [prd_pkg::BYTE_W-1:0]    rsp_packed_byte,
   output logic [prd_pkg::NIB_W-1:0]     rsp_new_index,
   output logic [prd_pkg::COLOR_W-1:0]   rsp_new_color,
   output logic                          rsp_success,
   output logic                          rsp_run_end
);
   import prd_pkg::*;

   localparam logic [1:0] ST_HEAD = 2'd0;
   localparam logic [1:0] ST_PAL  = 2'd1;
   localparam logic [1:0] ST_STAT = 2'd2;

   logic [1:0]          st_ff, st_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [COLOR_W-1:0]  sh_color_ff [SLOTS];
   logic [SLOTS-1:0]    sh_valid_ff;
   logic                sh_we;
   logic                sh_clear;
   logic                slot_free;
   logic                load_out;

   logic                out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]   o_kind, o_kind_ff;
   logic [BYTE_W-1:0]   o_byte, o_byte_ff;
   logic [NIB_W-1:0]    o_index, o_index_ff;
   logic [COLOR_W-1:0]  o_color, o_color_ff;
   logic                o_success, o_success_ff;
   logic                o_end, o_end_ff;

   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      st_in     = st_ff;
      idx_in    = idx_ff;
      q_pop     = 1'b0;
      load_out  = 1'b0;
      sh_we     = 1'b0;
      sh_clear  = 1'b0;
      o_kind    = RK_BYTE;
      o_byte    = '0;
      o_index   = '0;
      o_color   = '0;
      o_success = 1'b0;
      o_end     = 1'b0;
      case (st_ff)
         ST_HEAD: begin
            if (!q_empty) begin
               if (head.has_byte) begin
                  if (slot_free) begin
                     load_out = 1'b1;
                     o_byte   = head.packed_byte;
                     sh_we    = head.has_color;
                     if (head.has_end) begin
                        st_in = head.success ? ST_PAL : ST_STAT;
                     end else begin
                        q_pop = 1'b1;
                     end
                  end
               end else if (head.has_end) begin
                  sh_we = head.has_color;
                  st_in = head.success ? ST_PAL : ST_STAT;
               end else begin
                  sh_we = head.has_color;
                  q_pop = 1'b1;
               end
            end
         end
         ST_PAL: begin
            if (slot_free) begin
               load_out = 1'b1;
               o_kind   = RK_ENTRY;
               o_index  = NIB_W'(idx_ff);
               o_color  = sh_valid_ff[idx_ff] ? sh_color_ff[idx_ff] : '0;
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  idx_in = '0;
                  st_in  = ST_STAT;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_STAT: begin
            if (slot_free) begin
               load_out  = 1'b1;
               o_kind    = RK_STATUS;
               o_success = head.success;
               o_end     = 1'b1;
               q_pop     = 1'b1;
               sh_clear  = 1'b1;
               st_in     = ST_HEAD;
            end
         end
         default: begin
            st_in = ST_HEAD;
         end
      endcase
      out_valid_in = load_out || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_HEAD;
         idx_ff       <= '0;
         sh_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         if (sh_clear) begin
            sh_valid_ff <= '0;
         end else if (sh_we) begin
            sh_valid_ff[head.color_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sh_we) begin
         sh_color_ff[head.color_slot] <= head.color;
      end
      if (load_out) begin
         o_kind_ff    <= o_kind;
         o_byte_ff    <= o_byte;
         o_index_ff   <= o_index;
         o_color_ff   <= o_color;
         o_success_ff <= o_success;
         o_end_ff     <= o_end;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_kind = o_kind_ff;
   assign rsp_packed_byte = o_byte_ff;
   assign rsp_new_index   = o_index_ff;
   assign rsp_new_color   = o_color_ff;
   assign rsp_success     = o_success_ff;
   assign rsp_run_end     = o_end_ff;

   `PRD_ASSERT_IMPLIES(a_pal_needs_end, st_ff == ST_PAL,
      !q_empty && head.has_end && head.success, "palette dump without a good end command")
   `PRD_ASSERT_NEXT(a_stat_returns, (st_ff == ST_STAT) && slot_free,
      st_ff == ST_HEAD, "status transfer did not return to the head state")

endmodule

// File: tb/tb_palette_reduce_8bpp_to_4bpp.sv
// Testbench for the 8bpp to 4bpp palette reducer: random images checked against a model.
module tb_palette_reduce_8bpp_to_4bpp;
   timeunit 1ns;
   timeprecision 1ps;

   import prd_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  pbyte;
      logic [NIB_W-1:0]   slot;
      logic [COLOR_W-1:0] color;
      logic               ok;
      logic               done;
   } reduced_out_type;

   // Predicts the reduced stream and checks what the block sends back.
   class reduce_scoreboard;
      logic [COLOR_W-1:0] src_color [SRC_DEPTH];
      logic [COLOR_W-1:0] seen_color [SLOTS];
      int                 seen_n;
      logic [NIB_W-1:0]   high_nib;
      bit                 nib_held;
      bit                 too_many;
      reduced_out_type    owed [$];
      int                 mismatches;

      function new();
         mismatches = 0;
         restart_image();
      endfunction

      function void restart_image();
         foreach (seen_color[i]) seen_color[i] = '0;
         seen_n   = 0;
         high_nib = '0;
         nib_held = 0;
         too_many = 0;
      endfunction

      function void owe(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pbyte,
                        logic [NIB_W-1:0] slot, logic [COLOR_W-1:0] color,
                        logic ok, logic done);
         reduced_out_type r;
         r.kind  = kind;
         r.pbyte = pbyte;
         r.slot  = slot;
         r.color = color;
         r.ok    = ok;
         r.done  = done;
         owed.push_back(r);
      endfunction

      function void take_item(logic kind, logic [SRC_AW-1:0] eidx,
                              logic [COLOR_W-1:0] ecolor,
                              logic [SRC_AW-1:0] pix, logic last);
         logic [COLOR_W-1:0] c;
         logic [SLOT_W-1:0]  slot;
         bit                 hit;
         if (kind == ITEM_LOAD) begin
            src_color[eidx] = ecolor;
            return;
         end
         slot = '0;
         hit  = 0;
         // after an overflow, pixels are dropped until the last one
         if (!too_many) begin
            c = src_color[pix];
            for (int i = 0; i < seen_n; i++) begin
               if (!hit && seen_color[i] == c) begin
                  slot = i[SLOT_W-1:0];
                  hit  = 1;
               end
            end
            if (!hit) begin
               if (seen_n >= MAX_COLORS) begin
                  too_many = 1;
               end else begin
                  slot = seen_n[SLOT_W-1:0];
                  seen_color[seen_n] = c;
                  seen_n++;
               end
            end
            if (!too_many) begin
               if (nib_held) begin
                  owe(RK_BYTE, {high_nib, slot}, '0, '0, 1'b0, 1'b0);
                  nib_held = 0;
                  high_nib = '0;
               end else if (last) begin
                  owe(RK_BYTE, {slot, {NIB_W{1'b0}}}, '0, '0, 1'b0, 1'b0);
               end else begin
                  high_nib = slot;
                  nib_held = 1;
               end
            end
         end
         if (last) begin
            if (!too_many) begin
               for (int i = 0; i < SLOTS; i++)
                  owe(RK_ENTRY, '0, i[NIB_W-1:0], seen_color[i], 1'b0, 1'b0);
            end
            owe(RK_STATUS, '0, '0, '0, !too_many, 1'b1);
            restart_image();
         end
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void match_output(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pbyte,
                                 logic [NIB_W-1:0] slot, logic [COLOR_W-1:0] color,
                                 logic ok, logic done);
         reduced_out_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                     $time, kind, pbyte);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         field_check("result_kind", want.kind, kind);
         field_check("packed_byte", want.pbyte, pbyte);
         field_check("new_index", want.slot, slot);
         field_check("new_color", want.color, color);
         field_check("success", want.ok, ok);
         field_check("run_end", want.done, done);
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic                req_kind;
   logic [SRC_AW-1:0]   req_entry_index;
   logic [COLOR_W-1:0]  req_entry_color;
   logic [SRC_AW-1:0]   req_pixel;
   logic                req_last_pixel;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [KIND_W-1:0]   rsp_result_kind;
   logic [BYTE_W-1:0]   rsp_packed_byte;
   logic [NIB_W-1:0]    rsp_new_index;
   logic [COLOR_W-1:0]  rsp_new_color;
   logic                rsp_success;
   logic                rsp_run_end;

   palette_reduce_8bpp_to_4bpp uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_color (req_entry_color),
      .req_pixel       (req_pixel),
      .req_last_pixel  (req_last_pixel),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_new_index   (rsp_new_index),
      .rsp_new_color   (rsp_new_color),
      .rsp_success     (rsp_success),
      .rsp_run_end     (rsp_run_end)
   );

   reduce_scoreboard  sb = new();
   logic [SRC_AW-1:0] pool [$];
   bit                loaded [SRC_DEPTH];
   bit                send_calm;
   bit                take_calm;
   int                sent;

   always #5 clock = ~clock;

   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [SRC_AW-1:0] pool_at(int j);
      return pool[j % pool.size()];
   endfunction

   task automatic push_item(logic kind, logic [SRC_AW-1:0] eidx,
                            logic [COLOR_W-1:0] ecolor,
                            logic [SRC_AW-1:0] pix, logic last);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_kind        <= kind;
      req_entry_index <= eidx;
      req_entry_color <= ecolor;
      req_pixel       <= pix;
      req_last_pixel  <= last;
      do @(posedge clock); while (req_full);
      sb.take_item(kind, eidx, ecolor, pix, last);
      sent++;
   endtask

   task automatic send_load(logic [SRC_AW-1:0] idx, logic [COLOR_W-1:0] color, logic last);
      push_item(ITEM_LOAD, idx, color, $urandom_range(0, SRC_DEPTH - 1), last);
      if (!loaded[idx]) begin
         loaded[idx] = 1;
         pool.push_back(idx);
      end
   endtask

   task automatic send_pixel(logic [SRC_AW-1:0] p, logic last);
      push_item(ITEM_PIXEL, $urandom_range(0, SRC_DEPTH - 1), $urandom, p, last);
   endtask

   // One image: few colors, exactly sixteen, or more than sixteen.
   task automatic run_image();
      int                mode;
      int                k;
      int                n;
      int                len;
      int                base;
      logic [SRC_AW-1:0] p;
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, pool.size() - 1);
      if (mode < 6) begin
         k   = $urandom_range(1, 12);
         n   = 0;
         len = $urandom_range(1, 16);
      end else if (mode < 8) begin
         k   = MAX_COLORS;
         n   = MAX_COLORS;
         len = MAX_COLORS + $urandom_range(0, 6);
      end else begin
         k   = $urandom_range(MAX_COLORS + 1, pool.size());
         n   = MAX_COLORS + 1;
         len = n + $urandom_range(0, 8);
      end
      for (int j = 0; j < len; j++) begin
         if ($urandom_range(0, 11) == 0)
            send_load($urandom_range(0, SRC_DEPTH - 1), $urandom, $urandom_range(0, 1));
         p = (j < n) ? pool_at(base + j) : pool_at(base + $urandom_range(0, k - 1));
         send_pixel(p, j == len - 1);
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_kind        = ITEM_LOAD;
      req_entry_index = '0;
      req_entry_color = '0;
      req_pixel       = '0;
      req_last_pixel  = 1'b0;
      rsp_pop         = 1'b0;
      send_calm       = 0;
      take_calm       = 0;
      sent            = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, load with last set, one-pixel, odd and even images
      send_load(8'h00, 32'h0000_0000, 1'b0);
      send_load(8'hFF, 32'hFFFF_FFFF, 1'b1);
      send_load(8'h5A, 32'h1234_5678, 1'b0);
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h5A, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h5A, 1'b1);
      // reload an entry in the middle of an image
      send_pixel(8'hFF, 1'b0);
      send_load(8'h5A, 32'hFFFF_0000, 1'b0);
      send_pixel(8'h5A, 1'b1);

      while (pool.size() < 24)
         send_load($urandom_range(0, SRC_DEPTH - 1), $urandom, $urandom_range(0, 1));
      while (sent < 270)
         run_image();

      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Result side: pop with random stalls, check each transfer.
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         sb.match_output(rsp_result_kind, rsp_packed_byte, rsp_new_index,
                         rsp_new_color, rsp_success, rsp_run_end);
      end
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
